@@ sv/mbtpd_pkg.sv @@
// shared types and constants for the multi-button two-phase debouncer
package mbtpd_pkg;

   localparam int NUM_BUTTONS = 32;
   localparam int MASK_W      = 32;
   localparam int TIME_W      = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // register index, taken from csr_paddr[2]
   localparam logic REG_FIRST_WAIT  = 1'b0;
   localparam logic REG_SECOND_WAIT = 1'b1;

   typedef struct packed {
      logic [TIME_W-1:0] first_wait_us;
      logic [TIME_W-1:0] second_wait_us;
   } cfg_type;

   typedef struct packed {
      logic              step;
      logic [TIME_W-1:0] now_us;
   } lane_ctl_type;

endpackage

@@ sv/multi_button_two_phase_debouncer.sv @@
// top level: input word register, per-button lanes and result handshake
// an accepted word is registered, then updates the lanes once the result slot is free
// throughput: one word per cycle while rsp_tready stays high
// the lane state registers double as the result register; a stalled result holds them
// synchronous reset clears both channels' valid flags, every lane to idle and released,
// and both wait thresholds to zero
module multi_button_two_phase_debouncer (
   input  logic                                                clock,
   input  logic                                                reset,
   // req_tdata: sample_mask [31:0], now_us [63:32]
   input  logic                                                req_tvalid,
   output logic                                                req_tready,
   input  logic [mbtpd_pkg::MASK_W+mbtpd_pkg::TIME_W-1:0]      req_tdata,
   // rsp_tdata: stable_mask [31:0]
   output logic                                                rsp_tvalid,
   input  logic                                                rsp_tready,
   output logic [mbtpd_pkg::MASK_W-1:0]                        rsp_tdata,
   input  logic                                                csr_psel,
   input  logic                                                csr_penable,
   input  logic                                                csr_pwrite,
   input  logic [mbtpd_pkg::CSR_ADDR_W-1:0]                    csr_paddr,
   input  logic [mbtpd_pkg::CSR_DATA_W-1:0]                    csr_pwdata,
   output logic [mbtpd_pkg::CSR_DATA_W-1:0]                    csr_prdata,
   output logic                                                csr_pready
);

   mbtpd_pkg::cfg_type              cfg;
   mbtpd_pkg::lane_ctl_type         lane_ctl;

   logic                            in_valid_ff, in_valid_in;
   logic [mbtpd_pkg::MASK_W-1:0]    sample_ff;
   logic [mbtpd_pkg::TIME_W-1:0]    now_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            advance;
   logic                            step;
   logic [mbtpd_pkg::MASK_W-1:0]    stable_mask;

   mbtpd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // result slot is free or being emptied this cycle
   assign advance    = ~rsp_valid_ff | rsp_tready;
   assign step       = in_valid_ff & advance;
   assign req_tready = ~in_valid_ff | advance;

   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign rsp_valid_in = step | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready & req_tvalid) begin
         sample_ff <= req_tdata[mbtpd_pkg::MASK_W-1:0];
         now_ff    <= req_tdata[mbtpd_pkg::MASK_W+mbtpd_pkg::TIME_W-1:mbtpd_pkg::MASK_W];
      end
   end

   assign lane_ctl.step   = step;
   assign lane_ctl.now_us = now_ff;

   for (genvar i = 0; i < mbtpd_pkg::MASK_W; i++) begin : g_lane
      if (i < mbtpd_pkg::NUM_BUTTONS) begin : g_used
         mbtpd_lane u_lane (
            .clock  (clock),
            .reset  (reset),
            .ctl    (lane_ctl),
            .cfg    (cfg),
            .sample (sample_ff[i]),
            .stable (stable_mask[i])
         );
      end else begin : g_unused
         assign stable_mask[i] = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = stable_mask;

endmodule

@@ sv/mbtpd_csr.sv @@
// configuration registers behind the apb-style port
module mbtpd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mbtpd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [mbtpd_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [mbtpd_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready,
   output mbtpd_pkg::cfg_type                  cfg
);

   mbtpd_pkg::cfg_type cfg_ff, cfg_in;
   logic               wr_en;
   logic               reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            mbtpd_pkg::REG_FIRST_WAIT:  cfg_in.first_wait_us  = csr_pwdata;
            mbtpd_pkg::REG_SECOND_WAIT: cfg_in.second_wait_us = csr_pwdata;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   // reads with nonzero low address bits return zero; only csr_paddr[2] selects the word
   always_comb begin
      unique case (reg_sel)
         mbtpd_pkg::REG_FIRST_WAIT:  csr_prdata = cfg_ff.first_wait_us;
         mbtpd_pkg::REG_SECOND_WAIT: csr_prdata = cfg_ff.second_wait_us;
         default:                    csr_prdata = '0;
      endcase
      if (csr_paddr[1:0] != 2'b00) begin
         csr_prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ sv/mbtpd_lane.sv @@
// debounce state machine for one button bit
module mbtpd_lane (
   input  logic                      clock,
   input  logic                      reset,
   input  mbtpd_pkg::lane_ctl_type   ctl,
   input  mbtpd_pkg::cfg_type        cfg,
   input  logic                      sample,
   output logic                      stable
);

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_WAIT1 = 2'd1;
   localparam logic [1:0] PH_WAIT2 = 2'd2;

   logic [1:0]                    phase_ff, phase_in;
   logic                          stable_ff, stable_in;
   logic                          cand_ff, cand_in;
   logic [mbtpd_pkg::TIME_W-1:0]  start_ff, start_in;
   logic [mbtpd_pkg::TIME_W-1:0]  elapsed;
   logic [mbtpd_pkg::TIME_W-1:0]  limit;

   // wrapping difference handles timer rollover
   assign elapsed = ctl.now_us - start_ff;
   assign limit   = (phase_ff == PH_WAIT1) ? cfg.first_wait_us : cfg.second_wait_us;

   always_comb begin
      phase_in  = phase_ff;
      stable_in = stable_ff;
      cand_in   = cand_ff;
      start_in  = start_ff;
      unique case (phase_ff) inside
         PH_IDLE: begin
            if (sample != stable_ff) begin
               cand_in  = sample;
               start_in = ctl.now_us;
               phase_in = PH_WAIT1;
            end
         end
         PH_WAIT1, PH_WAIT2: begin
            if (sample != cand_ff) begin
               // bounce: restart timing under the second threshold
               cand_in  = sample;
               start_in = ctl.now_us;
               phase_in = PH_WAIT2;
            end else if (elapsed >= limit) begin
               stable_in = cand_ff;
               phase_in  = PH_IDLE;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         stable_ff <= 1'b0;
         cand_ff   <= 1'b0;
      end else if (ctl.step) begin
         phase_ff  <= phase_in;
         stable_ff <= stable_in;
         cand_ff   <= cand_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.step) begin
         start_ff <= start_in;
      end
   end

   assign stable = stable_ff;

endmodule

@@ sv/mbtpd_checker.sv @@
// port-level assertions for the debouncer, bound to the top level
module mbtpd_checker (
   input logic                                             clock,
   input logic                                             reset,
   input logic                                             req_tvalid,
   input logic                                             req_tready,
   input logic                                             rsp_tvalid,
   input logic                                             rsp_tready,
   input logic [mbtpd_pkg::MASK_W-1:0]                     rsp_tdata
);

   // no stale result survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // every accepted word must be followed by a result with rsp_tvalid high
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> ##2 rsp_tvalid)
      else $error("accepted word produced no result");

   // with the result slot empty the input side never stalls
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low with no pending result");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result word changed");

endmodule

bind multi_button_two_phase_debouncer mbtpd_checker u_mbtpd_checker (.*);
